// ===== rtl/core/rpc_pkg.sv =====
// Shared types, constants and helper functions for the rectangular/polar converter.
package rpc_pkg;

   localparam int ITERATIONS = 16;
   localparam int IW = 20;
   localparam int ZW = 34;
   localparam int PW = IW + 31;
   localparam int ANG_LIMIT = 25736;

   localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [30:0]   GAIN_Q30    = 31'sd652032874;

   // degrees Q8.7 to radians Q2.30: |d| * PI_Q30 = |d| * (23040 * PI_QUO + PI_REM)
   localparam logic signed [16:0] DEG_HALF_TURN = 17'sd23040;
   localparam logic signed [16:0] DEG_TURN      = 17'sd46080;
   localparam logic [17:0]        PI_QUO        = 18'd146408;
   localparam logic [14:0]        PI_REM        = 15'd19106;
   localparam logic [28:0]        DEG_RND       = 29'd11520;
   // floor(v / 45) = (v * DIV45_MUL) >> 26 for v < 2^20
   localparam logic [20:0]        DIV45_MUL     = 21'd1491309;

   typedef enum logic [1:0] {
      KIND_RECT  = 2'd0,
      KIND_POLAR = 2'd1,
      KIND_BAD   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic signed [15:0] xi;
      logic signed [15:0] yi;
      logic [14:0]        mag;
      logic signed [15:0] ang;
      logic               zero;
   } meta_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        mag;
      logic signed [15:0] ang;
      logic               form;
   } res_type;

   function automatic logic [29:0] atan_q30(input int idx);
      unique case (idx)
         0:  return 30'd843314856;
         1:  return 30'd497837829;
         2:  return 30'd263043836;
         3:  return 30'd133525158;
         4:  return 30'd67021687;
         5:  return 30'd33543515;
         6:  return 30'd16775850;
         7:  return 30'd8388437;
         8:  return 30'd4194282;
         9:  return 30'd2097149;
         10: return 30'd1048575;
         11: return 30'd524287;
         12: return 30'd262143;
         13: return 30'd131071;
         14: return 30'd65535;
         15: return 30'd32767;
         16: return 30'd16383;
         17: return 30'd8191;
         18: return 30'd4095;
         19: return 30'd2047;
         20: return 30'd1023;
         21: return 30'd511;
         22: return 30'd255;
         23: return 30'd127;
         default: return 30'd0;
      endcase
   endfunction

   // Q2.30 radians to Q3.13, round half up, clamp to +/- pi
   function automatic logic signed [15:0] angle_out(input logic signed [ZW-1:0] z);
      logic signed [ZW-1:0]  r;
      logic signed [ZW-18:0] s;
      r = z + ZW'(65536);
      s = r[ZW-1:17];
      if (s > (ZW-17)'(ANG_LIMIT)) begin
         return 16'(ANG_LIMIT);
      end else if (s < -(ZW-17)'(ANG_LIMIT)) begin
         return -16'(ANG_LIMIT);
      end
      return s[15:0];
   endfunction

   // gain product back to Q8.8, round half up
   function automatic logic signed [IW:0] gain_round(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] r;
      r = p + (PW'(1) <<< 29);
      return r[PW-1:30];
   endfunction

   function automatic logic signed [15:0] sat_s16(input logic signed [IW:0] v);
      if (v > (IW+1)'(32767)) begin
         return 16'sh7FFF;
      end else if (v < -(IW+1)'(32768)) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic logic [15:0] sat_u16(input logic signed [IW:0] v);
      if (v < 0) begin
         return 16'h0000;
      end else if (v > (IW+1)'(65535)) begin
         return 16'hFFFF;
      end
      return v[15:0];
   endfunction

endpackage

// ===== rtl/core/rect_polar_converter.sv =====
// Rectangular/polar vector converter built on a fully unrolled CORDIC pipeline.
// Throughput: one request per cycle while req_ready is high; the 16 CORDIC rotation stages are one per register.
// A single result skid register lets the pipe advance while a result waits on rsp_ready.
// Reset clears only valid bits; payload registers are not reset.
module rect_polar_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [15:0] req_x_in,
   input  logic signed [15:0] req_y_in,
   input  logic [14:0]        req_mag_in,
   input  logic signed [15:0] req_deg_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_x_out,
   output logic signed [15:0] rsp_y_out,
   output logic [15:0]        rsp_magnitude,
   output logic signed [15:0] rsp_angle_rad,
   output logic               rsp_form_out
);
   import rpc_pkg::*;

   logic adv;

   // stage 0: degree wrap and constant multiplies
   logic signed [16:0] deg_ext;
   logic signed [16:0] deg_wrap;
   logic [14:0]        deg_abs;
   meta_type           req_meta;
   logic [32:0]        p0_aq_in;
   logic [28:0]        p0_ar_in;

   logic        p0_vld_ff;
   meta_type    p0_meta_ff;
   logic        p0_neg_ff;
   logic [32:0] p0_aq_ff;
   logic [28:0] p0_ar_ff;

   // stage 1: divide remainder part by 23040
   logic [40:0] p1_prod_in;
   logic        p1_vld_ff;
   meta_type    p1_meta_ff;
   logic        p1_neg_ff;
   logic [32:0] p1_aq_ff;
   logic [14:0] p1_quo_ff;

   // stage 2: signed angle in Q2.30
   logic [32:0]          p2_q_in;
   logic signed [ZW-1:0] p2_z_in;
   logic                 p2_vld_ff;
   meta_type             p2_meta_ff;
   logic signed [ZW-1:0] p2_z_ff;

   // CORDIC stages
   meta_type             init_meta;
   logic signed [IW-1:0] init_x;
   logic signed [IW-1:0] init_y;
   logic signed [ZW-1:0] init_z;

   logic [ITERATIONS:0]  c_vld_ff;
   logic signed [IW-1:0] c_x_ff [0:ITERATIONS];
   logic signed [IW-1:0] c_y_ff [0:ITERATIONS];
   logic signed [ZW-1:0] c_z_ff [0:ITERATIONS];
   meta_type             c_meta_ff [0:ITERATIONS];

   // gain stage
   logic                 g_vld_ff;
   meta_type             g_meta_ff;
   logic signed [PW-1:0] g_px_ff;
   logic signed [PW-1:0] g_py_ff;
   logic signed [15:0]   g_ang_ff;

   // output
   logic signed [IW:0] res_px;
   logic signed [IW:0] res_py;
   res_type            res_in;
   res_type            out_ff;
   logic               out_vld_ff;
   res_type            skid_ff;
   logic               skid_vld_ff;

   assign adv       = !skid_vld_ff;
   assign req_ready = adv;

   always_comb begin
      deg_ext = 17'(req_deg_in);
      if (deg_ext > DEG_HALF_TURN) begin
         deg_wrap = deg_ext - DEG_TURN;
      end else if (deg_ext < -DEG_HALF_TURN) begin
         deg_wrap = deg_ext + DEG_TURN;
      end else begin
         deg_wrap = deg_ext;
      end
      deg_abs  = deg_wrap[16] ? 15'(-deg_wrap) : deg_wrap[14:0];
      p0_aq_in = 33'(deg_abs) * 33'(PI_QUO);
      p0_ar_in = 29'(deg_abs) * 29'(PI_REM) + DEG_RND;

      req_meta      = '0;
      req_meta.kind = kind_type'(req_kind);
      req_meta.xi   = req_x_in;
      req_meta.yi   = req_y_in;
      req_meta.mag  = req_mag_in;
   end

   assign p1_prod_in = 41'(p0_ar_ff[28:9]) * 41'(DIV45_MUL);
   assign p2_q_in    = p1_aq_ff + 33'(p1_quo_ff);
   assign p2_z_in    = p1_neg_ff ? -ZW'(p2_q_in) : ZW'(p2_q_in);

   always_comb begin
      init_meta      = p2_meta_ff;
      init_meta.ang  = angle_out(p2_z_ff);
      init_meta.zero = (p2_meta_ff.xi == '0) && (p2_meta_ff.yi == '0);
      init_x         = '0;
      init_y         = '0;
      init_z         = '0;
      if (p2_meta_ff.kind == KIND_POLAR) begin
         init_x = IW'(p2_meta_ff.mag);
         init_z = p2_z_ff;
         if (p2_z_ff > HALF_PI_Q30) begin
            init_x = -IW'(p2_meta_ff.mag);
            init_z = p2_z_ff - PI_Q30;
         end else if (p2_z_ff < -HALF_PI_Q30) begin
            init_x = -IW'(p2_meta_ff.mag);
            init_z = p2_z_ff + PI_Q30;
         end
      end else begin
         init_x = IW'(p2_meta_ff.xi);
         init_y = IW'(p2_meta_ff.yi);
         if (p2_meta_ff.xi < 0) begin
            init_z = (p2_meta_ff.yi >= 0) ? PI_Q30 : -PI_Q30;
            init_x = -IW'(p2_meta_ff.xi);
            init_y = -IW'(p2_meta_ff.yi);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff <= 1'b0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         c_vld_ff  <= '0;
         g_vld_ff  <= 1'b0;
      end else if (adv) begin
         p0_vld_ff <= req_valid;
         p1_vld_ff <= p0_vld_ff;
         p2_vld_ff <= p1_vld_ff;
         c_vld_ff  <= {c_vld_ff[ITERATIONS-1:0], p2_vld_ff};
         g_vld_ff  <= c_vld_ff[ITERATIONS];
      end
      if (adv) begin
         p0_meta_ff   <= req_meta;
         p0_neg_ff    <= deg_wrap[16];
         p0_aq_ff     <= p0_aq_in;
         p0_ar_ff     <= p0_ar_in;
         p1_meta_ff   <= p0_meta_ff;
         p1_neg_ff    <= p0_neg_ff;
         p1_aq_ff     <= p0_aq_ff;
         p1_quo_ff    <= p1_prod_in[40:26];
         p2_meta_ff   <= p1_meta_ff;
         p2_z_ff      <= p2_z_in;
         c_meta_ff[0] <= init_meta;
         c_x_ff[0]    <= init_x;
         c_y_ff[0]    <= init_y;
         c_z_ff[0]    <= init_z;
         g_meta_ff    <= c_meta_ff[ITERATIONS];
         g_px_ff      <= PW'(c_x_ff[ITERATIONS]) * PW'(GAIN_Q30);
         g_py_ff      <= PW'(c_y_ff[ITERATIONS]) * PW'(GAIN_Q30);
         g_ang_ff     <= angle_out(c_z_ff[ITERATIONS]);
      end
   end

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
      logic                 ccw;
      logic signed [IW-1:0] dx;
      logic signed [IW-1:0] dy;
      logic signed [ZW-1:0] da;

      always_comb begin
         dx = c_y_ff[k] >>> k;
         dy = c_x_ff[k] >>> k;
         da = ZW'(atan_q30(k));
         if (c_meta_ff[k].kind == KIND_POLAR) begin
            ccw = !c_z_ff[k][ZW-1];
         end else begin
            ccw = c_y_ff[k][IW-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            c_meta_ff[k+1] <= c_meta_ff[k];
            if (ccw) begin
               c_x_ff[k+1] <= c_x_ff[k] - dx;
               c_y_ff[k+1] <= c_y_ff[k] + dy;
               c_z_ff[k+1] <= c_z_ff[k] - da;
            end else begin
               c_x_ff[k+1] <= c_x_ff[k] + dx;
               c_y_ff[k+1] <= c_y_ff[k] - dy;
               c_z_ff[k+1] <= c_z_ff[k] + da;
            end
         end
      end
   end

   always_comb begin
      res_px = gain_round(g_px_ff);
      res_py = gain_round(g_py_ff);
      res_in = '0;
      unique case (g_meta_ff.kind)
         KIND_RECT: begin
            res_in.x = g_meta_ff.xi;
            res_in.y = g_meta_ff.yi;
            if (!g_meta_ff.zero) begin
               res_in.mag = sat_u16(res_px);
               res_in.ang = g_ang_ff;
            end
         end
         KIND_POLAR: begin
            res_in.x    = sat_s16(res_px);
            res_in.y    = sat_s16(res_py);
            res_in.mag  = 16'(g_meta_ff.mag);
            res_in.ang  = g_meta_ff.ang;
            res_in.form = 1'b1;
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            out_ff      <= skid_ff;
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_ff     <= res_in;
            out_vld_ff <= g_vld_ff;
         end
      end else if (g_vld_ff && adv) begin
         skid_ff     <= res_in;
         skid_vld_ff <= 1'b1;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_x_out     = out_ff.x;
   assign rsp_y_out     = out_ff.y;
   assign rsp_magnitude = out_ff.mag;
   assign rsp_angle_rad = out_ff.ang;
   assign rsp_form_out  = out_ff.form;

endmodule

// ===== tb/rect_polar_converter_test.sv =====
// Self-checking testbench for the rectangular/polar converter with its own CORDIC predictor.
module rect_polar_converter_test;
   import rpc_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;  // unused encoding, handled as invalid
   localparam longint HALF_TURN_Q30 = 64'sd3373259426;
   localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
   localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
   localparam longint ANGLE_CLAMP = 64'sd25736;
   localparam int CORDIC_STEPS = 16;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_REQUESTS = 215;
   localparam res_type ZERO_RESULT = '0;
   localparam res_type POLAR_ZERO = res_type'{16'sd0, 16'sd0, 16'd0, 16'sd0, 1'b1};

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        mag;
      logic signed [15:0] deg;
      bit                 known;
      res_type            want;
   } request_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_kind;
   logic signed [15:0] req_x_in;
   logic signed [15:0] req_y_in;
   logic [14:0]        req_mag_in;
   logic signed [15:0] req_deg_in;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_x_out;
   logic signed [15:0] rsp_y_out;
   logic [15:0]        rsp_magnitude;
   logic signed [15:0] rsp_angle_rad;
   logic               rsp_form_out;

   bit                 row_known;
   res_type            row_want;
   res_type            pending_conversions[$];
   res_type            oldest_conversion;
   request_row_type    directed_rows[$];
   longint             arctan_q30 [0:15] = '{843314856, 497837829, 263043836, 133525158,
      67021687, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767};

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_request;
   int  mismatches;
   int  results_seen;
   int  rect_count;
   int  polar_count;
   int  invalid_count;

   rect_polar_converter DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_x_in      (req_x_in),
      .req_y_in      (req_y_in),
      .req_mag_in    (req_mag_in),
      .req_deg_in    (req_deg_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_x_out     (rsp_x_out),
      .rsp_y_out     (rsp_y_out),
      .rsp_magnitude (rsp_magnitude),
      .rsp_angle_rad (rsp_angle_rad),
      .rsp_form_out  (rsp_form_out)
   );

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // undo CORDIC gain, back to Q8.8 rounding half up
   function automatic longint gain_comp(input longint v);
      return (v * CORDIC_GAIN_Q30 + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic signed [15:0] rad_q13(input longint z);
      return 16'(clip((z + 64'sd65536) >>> 17, -ANGLE_CLAMP, ANGLE_CLAMP));
   endfunction

   function automatic res_type convert_vector(input logic [1:0] kind,
                                              input logic signed [15:0] xi,
                                              input logic signed [15:0] yi,
                                              input logic [14:0] mi,
                                              input logic signed [15:0] di);
      res_type r;
      longint x, y, z, t, dx, dy, d, num, q;
      int i;
      r = ZERO_RESULT;
      if (kind == KIND_RECT) begin
         r.x = xi;
         r.y = yi;
         if (xi != 0 || yi != 0) begin
            x = xi;
            y = yi;
            z = 0;
            if (xi < 0) begin
               z = (yi >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
               x = -x;
               y = -y;
            end
            for (i = 0; i < CORDIC_STEPS; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y < 0) begin
                  t = x - dx; y = y + dy; x = t; z = z - arctan_q30[i];
               end else begin
                  t = x + dx; y = y - dy; x = t; z = z + arctan_q30[i];
               end
            end
            r.mag = 16'(clip(gain_comp(x), 0, 65535));
            r.ang = rad_q13(z);
         end
      end else if (kind == KIND_POLAR) begin
         d = di;
         if (d > 23040) begin
            d = d - 46080;
         end else if (d < -23040) begin
            d = d + 46080;
         end
         num = d * HALF_TURN_Q30;
         q = ((num < 0 ? -num : num) + 11520) / 23040;
         z = (num < 0) ? -q : q;
         r.ang = rad_q13(z);
         r.mag = {1'b0, mi};
         r.form = 1'b1;
         x = mi;
         y = 0;
         if (z > QUARTER_TURN_Q30) begin
            x = -x; z = z - HALF_TURN_Q30;
         end else if (z < -QUARTER_TURN_Q30) begin
            x = -x; z = z + HALF_TURN_Q30;
         end
         for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               t = x - dx; y = y + dy; x = t; z = z - arctan_q30[i];
            end else begin
               t = x + dx; y = y - dy; x = t; z = z + arctan_q30[i];
            end
         end
         r.x = 16'(clip(gain_comp(x), -32768, 32767));
         r.y = 16'(clip(gain_comp(y), -32768, 32767));
      end
      return r;
   endfunction

   function automatic request_row_type make_row(input logic [1:0] kind, input int xv,
                                                input int yv, input int mv, input int dv,
                                                input bit known, input res_type want);
      request_row_type r;
      r.kind = kind;
      r.x = 16'(xv);
      r.y = 16'(yv);
      r.mag = 15'(mv);
      r.deg = 16'(dv);
      r.known = known;
      r.want = want;
      return r;
   endfunction

   function automatic int sample_s16();
      int edges [5] = '{32767, -32768, 0, 1, -1};
      case ($urandom_range(3))
         0: return $signed($urandom_range(1023)) - 512;
         1: return edges[$urandom_range(4)];
         default: return $signed(16'($urandom));
      endcase
   endfunction

   function automatic request_row_type random_row();
      int pick;
      int mv;
      int dv;
      int angles [5] = '{23040, -23040, 11520, -11520, 0};
      logic [1:0] kind;
      pick = $urandom_range(99);
      kind = (pick < 45) ? KIND_RECT : (pick < 90) ? KIND_POLAR :
             (pick < 96) ? KIND_BAD : KIND_SPARE;
      case ($urandom_range(3))
         0: mv = $urandom_range(1023);
         1: mv = ($urandom_range(1) == 1) ? 32767 : 0;
         default: mv = $urandom_range(32767);
      endcase
      case ($urandom_range(9))
         0: dv = $signed(16'($urandom));
         1: dv = angles[$urandom_range(4)];
         default: dv = $signed($urandom_range(46080)) - 23040;
      endcase
      return make_row(kind, sample_s16(), sample_s16(), mv, dv, 1'b0, ZERO_RESULT);
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   task automatic offer(input request_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= r.kind;
      req_x_in   <= r.x;
      req_y_in   <= r.y;
      req_mag_in <= r.mag;
      req_deg_in <= r.deg;
      row_known  <= r.known;
      row_want   <= r.want;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_conversions.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   // receiver: random stalls plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         pending_conversions.push_back(row_known ? row_want :
            convert_vector(req_kind, req_x_in, req_y_in, req_mag_in, req_deg_in));
         if (req_kind == KIND_RECT) begin
            rect_count++;
         end else if (req_kind == KIND_POLAR) begin
            polar_count++;
         end else begin
            invalid_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_conversions.size() == 0) begin
            note_mismatch("result with no request outstanding");
         end else begin
            oldest_conversion = pending_conversions.pop_front();
            if (rsp_x_out !== oldest_conversion.x || rsp_y_out !== oldest_conversion.y ||
                rsp_magnitude !== oldest_conversion.mag ||
                rsp_angle_rad !== oldest_conversion.ang ||
                rsp_form_out !== oldest_conversion.form) begin
               note_mismatch($sformatf({"result %0d expected x=%0d y=%0d mag=%0d ang=%0d ",
                  "form=%0d, got x=%0d y=%0d mag=%0d ang=%0d form=%0d"}, results_seen,
                  oldest_conversion.x, oldest_conversion.y, oldest_conversion.mag,
                  oldest_conversion.ang, oldest_conversion.form, rsp_x_out, rsp_y_out,
                  rsp_magnitude, rsp_angle_rad, rsp_form_out));
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_RECT;
      req_x_in = '0;
      req_y_in = '0;
      req_mag_in = '0;
      req_deg_in = '0;
      row_known = 1'b0;
      row_want = ZERO_RESULT;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      directed_rows.push_back(make_row(KIND_RECT, 0, 0, 0, 0, 1'b1, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, 32767, 32767, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, -32768, -32768, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, 32767, -32768, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, -32768, 0, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, -256, -1, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, 0, 32767, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, 0, -32768, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, 1, 0, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, -1, 0, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_RECT, 0, 1, 0, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 0, 0, 1'b1, POLAR_ZERO));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 32767, 0, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 32767, 23040, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 32767, -23040, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 32767, 11520, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 32767, -11520, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 32767, 5760, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 256, 23041, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 256, -23041, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 32767, 32767, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_POLAR, 0, 0, 32767, -32768, 1'b0, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_BAD, -1, -1, 32767, -1, 1'b1, ZERO_RESULT));
      directed_rows.push_back(make_row(KIND_SPARE, 32767, -32768, 32767, 23040, 1'b1,
                                       ZERO_RESULT));
      foreach (directed_rows[i]) begin
         offer(directed_rows[i]);
      end
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 47 : (phase == 3) ? 20 : 0;
         recv_stall_pct = (phase == 2) ? 47 : (phase == 3) ? 20 : 0;
         repeat (PHASE_REQUESTS) offer(random_row());
         drain();
      end

      // long receiver hold-off with a steady stream: pipeline fills and backpressures
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b1;
      repeat (60) offer(random_row());
      drain();

      repeat (40) @(posedge clock);
      $display("checked %0d results: %0d rectangular, %0d polar, %0d invalid requests",
               results_seen, rect_count, polar_count, invalid_count);
      $display("covered field extremes, angle wrap past 180 degrees, stalls and backpressure");
      if (mismatches == 0 && pending_conversions.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  pending_conversions.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/rpc_pkg.sv
rtl/core/rect_polar_converter.sv
tb/rect_polar_converter_test.sv
